/* rtl/core/ucv_pkg.sv */
// Shared types and constants for the UTF-8 to UTF-16 converter.
package ucv_pkg;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = 2;
    localparam int unsigned FIFO_CW    = 3;

    localparam logic [15:0] CAP_RESET = 16'd256;
    localparam logic [15:0] QMARK     = 16'h003F;
    localparam logic [15:0] HI_SURR   = 16'hD800;
    localparam logic [15:0] LO_SURR   = 16'hDC00;
    localparam logic [19:0] SUPP_BASE = 20'h10000;

    // continuation bytes of a 4-byte sequence
    localparam logic [1:0] SEQ_FOUR = 2'd3;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        end_of_string;
        logic [15:0] units_written;
        logic        last_of_run;
    } t_result;

    // results produced by one byte: count is 0, 1 or 2
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

endpackage

/* rtl/core/utf8_to_utf16_converter.sv */
// Top level of the UTF-8 to UTF-16 stream converter.
//
//   channel   dir  handshake              payload
//   s (bytes) in   i_s_tvalid/o_s_tready  i_s_tdata[7:0] input_byte
//   m (units) out  o_m_tvalid/i_m_tready  tdata {units_written, code_unit}, tuser eos,
//                                         tlast last_of_run
//   cfg       in   i_cfg_wr_en            i_cfg_wr_data out_capacity
//
// One byte per cycle while the queue has room: a byte is held in the input register and
// decoded there; its results land in a four-entry queue, first one visible the next
// cycle. Units leave one per cycle while i_m_tready is high.
// Input stalls only while the queue lacks room for two results.
// Synchronous active-low reset; capacity resets to 256.
module utf8_to_utf16_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,      // [7:0] input_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,      // [15:0] code_unit, [31:16] units_written
    output logic        o_m_tuser,      // [0] end_of_string
    output logic        o_m_tlast,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data
);

    logic [15:0]      r_capacity;
    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             room;
    logic             proc;
    ucv_pkg::t_push   push;
    ucv_pkg::t_result result;

    assign proc       = r_in_valid && room;
    assign o_s_tready = !r_in_valid || room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= ucv_pkg::CAP_RESET;
            r_in_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_capacity <= i_cfg_wr_data;
            end
            if (i_s_tvalid && o_s_tready) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_byte <= i_s_tdata;
        end
    end

    ucv_decode u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (proc),
        .i_byte     (r_in_byte),
        .i_capacity (r_capacity),
        .o_push     (push)
    );

    ucv_result_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_room   (room),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_result (result)
    );

    assign o_m_tdata = {result.units_written, result.code_unit};
    assign o_m_tuser = result.end_of_string;
    assign o_m_tlast = result.last_of_run;

endmodule

/* rtl/core/ucv_decode.sv */
// Per-string decode state and the combinational byte decoder.
module ucv_decode (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [7:0]           i_byte,
    input  logic [15:0]          i_capacity,
    output ucv_pkg::t_push       o_push
);

    logic [1:0]  r_pend, n_pend;
    logic [20:0] r_pc, n_pc;
    logic [1:0]  r_seq, n_seq;
    logic [15:0] r_uc, n_uc;
    logic        r_full, n_full;

    logic [20:0] pc_shift;
    logic [19:0] cp;
    logic [16:0] uc_p1, uc_p2, cap17;
    ucv_pkg::t_push push;

    always_comb begin
        n_pend   = r_pend;
        n_pc     = r_pc;
        n_seq    = r_seq;
        n_uc     = r_uc;
        n_full   = r_full;
        push     = '0;
        pc_shift = {r_pc[14:0], i_byte[5:0]};
        cp       = pc_shift[19:0] - ucv_pkg::SUPP_BASE;
        uc_p1    = {1'b0, r_uc} + 17'd1;
        uc_p2    = {1'b0, r_uc} + 17'd2;
        cap17    = {1'b0, i_capacity};
        if (i_valid) begin
            if (i_byte == 8'd0) begin
                push.count               = 2'd1;
                push.res0.end_of_string  = 1'b1;
                push.res0.units_written  = r_uc;
                push.res0.last_of_run    = 1'b1;
                n_pend = '0;
                n_pc   = '0;
                n_seq  = '0;
                n_uc   = '0;
                n_full = 1'b0;
            end else if (!r_full) begin
                if (r_pend != 2'd0) begin
                    n_pc   = pc_shift;
                    n_pend = r_pend - 2'd1;
                    if (r_pend == 2'd1) begin
                        n_seq = '0;
                        if (r_seq == ucv_pkg::SEQ_FOUR) begin
                            if (uc_p2 < cap17) begin
                                push.count            = 2'd2;
                                push.res0.code_unit   = ucv_pkg::HI_SURR | {6'd0, cp[19:10]};
                                push.res1.code_unit   = ucv_pkg::LO_SURR | {6'd0, cp[9:0]};
                                push.res1.last_of_run = 1'b1;
                                n_uc = uc_p2[15:0];
                            end else begin
                                // pair does not fit: one '?' instead
                                push.count            = 2'd1;
                                push.res0.code_unit   = ucv_pkg::QMARK;
                                push.res0.last_of_run = 1'b1;
                                n_uc = uc_p1[15:0];
                            end
                        end else begin
                            push.count            = 2'd1;
                            push.res0.code_unit   = pc_shift[15:0];
                            push.res0.last_of_run = 1'b1;
                            n_uc = uc_p1[15:0];
                        end
                    end
                end else if (!(uc_p1 < cap17)) begin
                    n_full = 1'b1;
                end else if (!i_byte[7]) begin
                    push.count            = 2'd1;
                    push.res0.code_unit   = {8'd0, i_byte};
                    push.res0.last_of_run = 1'b1;
                    n_uc = uc_p1[15:0];
                end else if (i_byte[7:5] == 3'b110) begin
                    n_pc   = {16'd0, i_byte[4:0]};
                    n_pend = 2'd1;
                    n_seq  = 2'd1;
                end else if (i_byte[7:4] == 4'b1110) begin
                    n_pc   = {17'd0, i_byte[3:0]};
                    n_pend = 2'd2;
                    n_seq  = 2'd2;
                end else if (i_byte[7:3] == 5'b11110) begin
                    n_pc   = {18'd0, i_byte[2:0]};
                    n_pend = 2'd3;
                    n_seq  = ucv_pkg::SEQ_FOUR;
                end else begin
                    // stray continuation byte or 0xF8..0xFF as lead
                    push.count            = 2'd1;
                    push.res0.code_unit   = ucv_pkg::QMARK;
                    push.res0.last_of_run = 1'b1;
                    n_uc = uc_p1[15:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_pc   <= '0;
            r_seq  <= '0;
            r_uc   <= '0;
            r_full <= 1'b0;
        end else begin
            r_pend <= n_pend;
            r_pc   <= n_pc;
            r_seq  <= n_seq;
            r_uc   <= n_uc;
            r_full <= n_full;
        end
    end

    assign o_push = push;

    a_pair_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.count == 2'd2) |-> (!push.res0.last_of_run && push.res1.last_of_run))
        else $error("surrogate pair marks last on the wrong unit");

    a_eos_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.count == 2'd1 && push.res0.end_of_string)
            |=> (r_uc == 16'd0 && r_pend == 2'd0 && !r_full))
        else $error("string state not cleared after terminator");

endmodule

/* rtl/core/ucv_result_fifo.sv */
// Four-entry result queue taking up to two results per cycle, one out per cycle while i_ready is high.
module ucv_result_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ucv_pkg::t_push       i_push,
    output logic                 o_room,
    output logic                 o_valid,
    input  logic                 i_ready,
    output ucv_pkg::t_result     o_result
);

    ucv_pkg::t_result r_mem [ucv_pkg::FIFO_DEPTH];
    logic [ucv_pkg::FIFO_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [ucv_pkg::FIFO_CW-1:0] r_count;
    logic                        pop;
    logic [ucv_pkg::FIFO_AW-1:0] wr_ptr_p1;

    assign pop       = o_valid && i_ready;
    assign wr_ptr_p1 = r_wr_ptr + ucv_pkg::FIFO_AW'(1);
    assign o_valid   = (r_count != '0);
    assign o_result  = r_mem[r_rd_ptr];
    // room for a full pair
    assign o_room    = (r_count <= ucv_pkg::FIFO_CW'(ucv_pkg::FIFO_DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_ptr_p1] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + ucv_pkg::FIFO_AW'(i_push.count);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + ucv_pkg::FIFO_AW'(1);
            end
            r_count <= r_count + ucv_pkg::FIFO_CW'(i_push.count)
                       - ucv_pkg::FIFO_CW'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count != 2'd0) |-> (r_count <= ucv_pkg::FIFO_CW'(ucv_pkg::FIFO_DEPTH - 2)))
        else $error("result queue pushed without room");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ucv_pkg::FIFO_CW'(ucv_pkg::FIFO_DEPTH))
        else $error("result queue count out of range");

endmodule

/* dv/utf8_to_utf16_converter_test.sv */
// Self-checking stream testbench for the UTF-8 to UTF-16 converter.
module utf8_to_utf16_converter_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PHASE_BYTES    = 230;

    typedef logic [7:0] t_byte_q[$];

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;
    logic        o_m_tuser;
    logic        o_m_tlast;
    logic        i_cfg_wr_en = 1'b0;
    logic [15:0] i_cfg_wr_data = '0;

    utf8_to_utf16_converter dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),     // [7:0] input_byte
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata),     // [15:0] code_unit, [31:16] units_written
        .o_m_tuser    (o_m_tuser),     // [0] end_of_string
        .o_m_tlast    (o_m_tlast),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data)
    );

    always #10 i_clk = ~i_clk;

    // transcoder state as seen from outside
    logic [15:0] capacity   = ucv_pkg::CAP_RESET;
    logic [1:0]  conts_left = '0;
    logic [20:0] code_acc   = '0;
    logic [1:0]  seq_conts  = '0;
    logic [15:0] units_out  = '0;
    logic        string_full = 1'b0;

    ucv_pkg::t_result expected_units[$];
    int      errors = 0;
    int      bytes_sent = 0;
    int      src_idle_pct = 0;
    int      sink_stall_pct = 0;
    int      quiet_cycles = 0;

    function automatic void push_unit(logic [15:0] code, logic eos, logic [15:0] written,
                                      logic last);
        ucv_pkg::t_result r;
        r.code_unit     = code;
        r.end_of_string = eos;
        r.units_written = written;
        r.last_of_run   = last;
        expected_units.push_back(r);
    endfunction

    function automatic void transcode_byte(logic [7:0] b);
        logic [19:0] offset;
        if (b == 8'h00) begin
            push_unit(16'h0000, 1'b1, units_out, 1'b1);
            conts_left  = '0;
            code_acc    = '0;
            seq_conts   = '0;
            units_out   = '0;
            string_full = 1'b0;
            return;
        end
        if (string_full)
            return;
        if (conts_left != 0) begin
            code_acc   = {code_acc[14:0], b[5:0]};
            conts_left = conts_left - 2'd1;
            if (conts_left != 0)
                return;
            if (seq_conts == ucv_pkg::SEQ_FOUR) begin
                seq_conts = '0;
                if (({1'b0, units_out} + 17'd2) < {1'b0, capacity}) begin
                    offset = code_acc[19:0] - ucv_pkg::SUPP_BASE;
                    push_unit(ucv_pkg::HI_SURR | {6'b0, offset[19:10]}, 1'b0, 16'h0000,
                              1'b0);
                    push_unit(ucv_pkg::LO_SURR | {6'b0, offset[9:0]}, 1'b0, 16'h0000,
                              1'b1);
                    units_out = units_out + 16'd2;
                end else begin
                    push_unit(ucv_pkg::QMARK, 1'b0, 16'h0000, 1'b1);
                    units_out = units_out + 16'd1;
                end
                return;
            end
            seq_conts = '0;
            push_unit(code_acc[15:0], 1'b0, 16'h0000, 1'b1);
            units_out = units_out + 16'd1;
            return;
        end
        // a lead byte needs room for one unit plus the terminator
        if (!(({1'b0, units_out} + 17'd1) < {1'b0, capacity})) begin
            string_full = 1'b1;
            return;
        end
        if (b[7] == 1'b0) begin
            push_unit({8'h00, b}, 1'b0, 16'h0000, 1'b1);
            units_out = units_out + 16'd1;
        end else if (b[7:5] == 3'b110) begin
            code_acc   = {16'b0, b[4:0]};
            conts_left = 2'd1;
            seq_conts  = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
            code_acc   = {17'b0, b[3:0]};
            conts_left = 2'd2;
            seq_conts  = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
            code_acc   = {18'b0, b[2:0]};
            conts_left = 2'd3;
            seq_conts  = ucv_pkg::SEQ_FOUR;
        end else begin
            push_unit(ucv_pkg::QMARK, 1'b0, 16'h0000, 1'b1);
            units_out = units_out + 16'd1;
        end
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        do @(posedge i_clk); while (!o_s_tready);
        transcode_byte(b);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_bytes(input t_byte_q seq);
        foreach (seq[i])
            send_byte(seq[i]);
    endtask

    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (expected_units.size() != 0)
            @(posedge i_clk);
        // dropped bytes leave no result, so give the pipeline time to empty
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_capacity(input logic [15:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        capacity = value;
    endtask

    function automatic logic [7:0] cont_byte();
        // continuation bytes are not checked, so any nonzero byte may stand here
        if ($urandom_range(9) == 0)
            return 8'($urandom_range(1, 255));
        return {2'b10, 6'($urandom)};
    endfunction

    function automatic logic [7:0] lead_byte(int conts);
        case (conts)
            1:       return {3'b110, 5'($urandom)};
            2:       return {4'b1110, 4'($urandom)};
            default: return {5'b11110, 3'($urandom)};
        endcase
    endfunction

    task automatic send_random_string();
        t_byte_q seq;
        int      n_chars;
        int      sel;
        int      n_cont;
        bit      cut;
        n_chars = $urandom_range(0, 12);
        cut = 1'b0;
        for (int i = 0; i < n_chars && !cut; i++) begin
            sel = $urandom_range(99);
            n_cont = 0;
            if (sel < 40) begin
                seq.push_back(8'($urandom_range(1, 127)));
            end else if (sel < 85) begin
                n_cont = (sel < 55) ? 1 : (sel < 70) ? 2 : 3;
                seq.push_back(lead_byte(n_cont));
            end else if (sel < 90) begin
                if ($urandom_range(1) == 0)
                    seq.push_back(8'($urandom_range(8'h80, 8'hBF)));
                else
                    seq.push_back(8'($urandom_range(8'hF8, 8'hFF)));
            end else if (sel < 95) begin
                // truncated sequence: the terminator follows at once
                sel = $urandom_range(1, 3);
                seq.push_back(lead_byte(sel));
                n_cont = $urandom_range(0, sel - 1);
                cut = 1'b1;
            end else begin
                seq.push_back(8'($urandom_range(1, 255)));
            end
            repeat (n_cont) seq.push_back(cont_byte());
        end
        seq.push_back(8'h00);
        send_bytes(seq);
    endtask

    task automatic test_char_forms();
        wait_idle();
        set_capacity(ucv_pkg::CAP_RESET);
        send_bytes('{8'h41, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC,
                     8'hF0, 8'h9F, 8'h98, 8'h80, 8'h00});
    endtask

    task automatic test_odd_bytes();
        // illegal leads, unchecked continuation, code point wrap, truncation
        send_bytes('{8'h80, 8'hFF, 8'hC3, 8'hFF, 8'hF7, 8'hBF, 8'hBF, 8'hBF,
                     8'hE2, 8'h82, 8'h00});
    endtask

    task automatic test_capacity_edges();
        wait_idle();
        set_capacity(16'd1);
        send_bytes('{8'h41, 8'h00});
        wait_idle();
        // first unit fits, the pair after it does not
        set_capacity(16'd3);
        send_bytes('{8'h41, 8'hF0, 8'h9F, 8'h98, 8'h80, 8'h42, 8'h00});
        wait_idle();
        set_capacity(16'd4);
        send_bytes('{8'h41});
        wait_idle();
        // capacity lowered in the middle of a string
        set_capacity(16'd2);
        send_bytes('{8'h42, 8'h00});
    endtask

    task automatic test_random_traffic();
        int          start;
        logic [15:0] cap_pick;
        for (int p = 0; p < 8; p++) begin
            wait_idle();
            case (p % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 59; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 59; end
                default: begin src_idle_pct = 8; sink_stall_pct = 8; end
            endcase
            case (p)
                0: cap_pick = 16'd65535;
                1: cap_pick = 16'd1;
                2: cap_pick = 16'd5;
                3: cap_pick = ucv_pkg::CAP_RESET;
                4: cap_pick = 16'd3;
                5: cap_pick = 16'd12;
                6: cap_pick = 16'($urandom_range(1, 40));
                default: cap_pick = 16'($urandom_range(1, 65535));
            endcase
            set_capacity(cap_pick);
            start = bytes_sent;
            while (bytes_sent - start < PHASE_BYTES)
                send_random_string();
        end
    endtask

    always @(negedge i_clk)
        i_m_tready <= ($urandom_range(99) >= sink_stall_pct);

    always @(posedge i_clk) begin : check_units
        ucv_pkg::t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_units.size() == 0) begin
                $error("unexpected item: code_unit %h end_of_string %b", o_m_tdata[15:0],
                       o_m_tuser);
                errors++;
            end else begin
                want = expected_units.pop_front();
                if (o_m_tdata[15:0] !== want.code_unit) begin
                    $error("code_unit: expected %h, got %h", want.code_unit, o_m_tdata[15:0]);
                    errors++;
                end
                if (o_m_tuser !== want.end_of_string) begin
                    $error("end_of_string: expected %b, got %b", want.end_of_string, o_m_tuser);
                    errors++;
                end
                if (o_m_tdata[31:16] !== want.units_written) begin
                    $error("units_written: expected %0d, got %0d", want.units_written,
                           o_m_tdata[31:16]);
                    errors++;
                end
                if (o_m_tlast !== want.last_of_run) begin
                    $error("last_of_run: expected %b, got %b", want.last_of_run, o_m_tlast);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** utf8_to_utf16_converter: FAILED **");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_char_forms();
        test_odd_bytes();
        test_capacity_edges();
        test_random_traffic();
        wait_idle();
        if (errors == 0)
            $display("** utf8_to_utf16_converter: PASSED **");
        else
            $display("** utf8_to_utf16_converter: FAILED **");
        $finish;
    end

endmodule
